### design/neighbor_aging_table_macros.svh
// Assertion macros shared by the neighbor aging table.
`ifndef NEIGHBOR_AGING_TABLE_MACROS_SVH
`define NEIGHBOR_AGING_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NAT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/nat_pkg.sv
// Shared codes, entry layout and controller interface types for the neighbor table.
package nat_pkg;

  localparam logic [1:0] MODE_HELLO = 2'd0;
  localparam logic [1:0] MODE_SWEEP = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] EV_APPEAR     = 3'd0;
  localparam logic [2:0] EV_REFRESH    = 3'd1;
  localparam logic [2:0] EV_FULL       = 3'd2;
  localparam logic [2:0] EV_DISAPPEAR  = 3'd3;
  localparam logic [2:0] EV_SWEEP_DONE = 3'd4;
  localparam logic [2:0] EV_CLEARED    = 3'd5;

  localparam int ADDR_W        = 8;
  localparam int TIME_W        = 32;
  localparam int HOLD_W        = 16;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic load;
    logic read;
    logic refresh;
    logic append;
    logic full;
    logic drop;
    logic keep;
    logic sweep_done;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic rd_valid;
    logic hit;
    logic expired;
    logic full;
  } status_t;

endpackage

### design/neighbor_aging_table.sv
// Top level of the neighbor table with expiry deadlines.
//
//   channel  handshake               beat contents
//   input    start, busy             mode, sender_address, now_ms
//   config   hold_we                 hold_time_ms
//   result   result_strobe           event_res, node_address, entry_count, last
//
// A hello or sweep raises busy after its start beat and holds it while the walk reads the listed
// entries in turn; a hello that hits leaves the walk early.
// The entry memory gives one read per cycle, which sets the pace of the walk.
// Its final result comes in the first cycle after busy falls; a clear beat answers in the
// next cycle and never raises busy. Results cannot be held off: each beat shows for one cycle.
// Reset empties the table and loads the hold time with 5000.
`include "neighbor_aging_table_macros.svh"

module neighbor_aging_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [nat_pkg::ADDR_W-1:0]        sender_address,
  input  logic [nat_pkg::TIME_W-1:0]        now_ms,
  input  logic                              hold_we,
  input  logic [nat_pkg::HOLD_W-1:0]        hold_time_ms,
  output logic                              result_strobe,
  output logic [2:0]                        event_res,
  output logic [nat_pkg::ADDR_W-1:0]        node_address,
  output logic [nat_pkg::ENTRY_COUNT_W-1:0] entry_count,
  output logic                              last
);

  nat_pkg::cmd_t    cmd;
  nat_pkg::status_t status;
  logic             walk_beat;

  nat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  nat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .hold_we        (hold_we),
    .hold_time_ms   (hold_time_ms),
    .sender_address (sender_address),
    .now_ms         (now_ms),
    .result_strobe  (result_strobe),
    .event_res      (event_res),
    .node_address   (node_address),
    .entry_count    (entry_count),
    .last           (last)
  );

  assign walk_beat = start && !busy &&
                     (mode == nat_pkg::MODE_HELLO || mode == nat_pkg::MODE_SWEEP);

  `NAT_ASSERT_NEXT(a_walk_starts, clk, rst, walk_beat, busy, "walk did not start")
  `NAT_ASSERT_NOW(a_final_frees, clk, rst, result_strobe && last, !busy, "busy after last beat")
  `NAT_ASSERT_NOW(a_mid_busy, clk, rst, result_strobe && !last, busy, "early result while idle")
  `NAT_ASSERT_NOW(a_count_bound, clk, rst, result_strobe, entry_count <= TABLE_DEPTH, "bad count")

endmodule

### design/nat_ctrl.sv
// Controller: walks the table for hello and sweep items and sequences the datapath.
module nat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         mode,
  input  nat_pkg::status_t   status,
  output nat_pkg::cmd_t      cmd,
  output logic               busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic op_hello;
  logic op_hello_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op_hello <= 1'b0;
    end else begin
      state    <= state_next;
      op_hello <= op_hello_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    op_hello_next = op_hello;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            nat_pkg::MODE_HELLO, nat_pkg::MODE_SWEEP: begin
              cmd.load      = 1'b1;
              op_hello_next = (mode == nat_pkg::MODE_HELLO);
              state_next    = ST_SCAN;
            end
            nat_pkg::MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.rd_valid && op_hello && status.hit) begin
          cmd.refresh = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          // During a sweep each entry read back is either dropped or
          // copied down to the compaction pointer.
          if (status.rd_valid && !op_hello) begin
            if (status.expired) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.keep = 1'b1;
            end
          end
          if (status.more) begin
            cmd.read = 1'b1;
          end else if (!status.rd_valid) begin
            if (op_hello) begin
              if (status.full) begin
                cmd.full = 1'b1;
              end else begin
                cmd.append = 1'b1;
              end
            end else begin
              cmd.sweep_done = 1'b1;
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### design/nat_dp.sv
// Datapath: entry memory, count, scan pointers, hold time register and result register.
module nat_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  nat_pkg::cmd_t                     cmd,
  output nat_pkg::status_t                  status,
  input  logic                              hold_we,
  input  logic [nat_pkg::HOLD_W-1:0]        hold_time_ms,
  input  logic [nat_pkg::ADDR_W-1:0]        sender_address,
  input  logic [nat_pkg::TIME_W-1:0]        now_ms,
  output logic                              result_strobe,
  output logic [2:0]                        event_res,
  output logic [nat_pkg::ADDR_W-1:0]        node_address,
  output logic [nat_pkg::ENTRY_COUNT_W-1:0] entry_count,
  output logic                              last
);

  localparam int IW      = $clog2(TABLE_DEPTH);
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int CntOutW = nat_pkg::ENTRY_COUNT_W;

  nat_pkg::entry_t mem [TABLE_DEPTH];

  logic [nat_pkg::HOLD_W-1:0] hold;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              total;
  logic [CW-1:0]              rd_ptr;
  logic [CW-1:0]              wr_ptr;
  logic [IW-1:0]              rd_idx;
  logic                       rd_valid;
  nat_pkg::entry_t            rd_data;
  logic [nat_pkg::ADDR_W-1:0] sender_q;
  logic [nat_pkg::TIME_W-1:0] now_q;
  logic [nat_pkg::TIME_W-1:0] deadline_q;

  logic                       we;
  logic [IW-1:0]              wa;
  nat_pkg::entry_t            wd;
  logic                       emit;
  logic [2:0]                 ev;
  logic [nat_pkg::ADDR_W-1:0] ev_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold          <= nat_pkg::HOLD_RESET;
      count         <= '0;
      rd_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (hold_we) begin
        hold <= hold_time_ms;
      end
      count         <= count_next;
      rd_valid      <= cmd.read;
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sender_q   <= sender_address;
      now_q      <= now_ms;
      deadline_q <= now_ms + {{(nat_pkg::TIME_W - nat_pkg::HOLD_W){1'b0}}, hold};
      total      <= count;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
    end else begin
      if (cmd.read) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      if (cmd.keep) begin
        wr_ptr <= wr_ptr + CW'(1);
      end
    end
    if (cmd.read) begin
      rd_idx  <= rd_ptr[IW-1:0];
      rd_data <= mem[rd_ptr[IW-1:0]];
    end
    if (emit) begin
      event_res    <= ev;
      node_address <= ev_addr;
      entry_count  <= CntOutW'(count_next);
      last         <= !cmd.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // The compaction write never reaches the entry being read, since the
  // write pointer trails the read pointer.
  always_comb begin
    we = cmd.refresh || cmd.append || cmd.keep;
    if (cmd.refresh) begin
      wa = rd_idx;
    end else if (cmd.append) begin
      wa = count[IW-1:0];
    end else begin
      wa = wr_ptr[IW-1:0];
    end
    if (cmd.keep) begin
      wd = rd_data;
    end else begin
      wd.addr     = sender_q;
      wd.deadline = deadline_q;
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.append) begin
      count_next = count + CW'(1);
    end else if (cmd.drop) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    emit = cmd.refresh || cmd.append || cmd.full || cmd.drop || cmd.sweep_done ||
           cmd.clear;
    ev      = nat_pkg::EV_CLEARED;
    ev_addr = '0;
    if (cmd.refresh) begin
      ev      = nat_pkg::EV_REFRESH;
      ev_addr = sender_q;
    end else if (cmd.append) begin
      ev      = nat_pkg::EV_APPEAR;
      ev_addr = sender_q;
    end else if (cmd.full) begin
      ev      = nat_pkg::EV_FULL;
      ev_addr = sender_q;
    end else if (cmd.drop) begin
      ev      = nat_pkg::EV_DISAPPEAR;
      ev_addr = rd_data.addr;
    end else if (cmd.sweep_done) begin
      ev = nat_pkg::EV_SWEEP_DONE;
    end
  end

  assign status.more     = (rd_ptr < total);
  assign status.rd_valid = rd_valid;
  assign status.hit      = (rd_data.addr == sender_q);
  assign status.expired  = (rd_data.deadline < now_q);
  assign status.full     = (count == CW'(TABLE_DEPTH));

endmodule

### dv/tb_top.sv
// Self-checking testbench for the neighbor aging table: directed and random beats.
module tb_top;

  localparam int DEPTH  = 16;
  localparam int SETTLE = 24;

  typedef enum {STEP_BEAT, STEP_HOLD_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t                 kind;
    logic [1:0]                 op;
    logic [nat_pkg::ADDR_W-1:0] who;
    logic [nat_pkg::TIME_W-1:0] at_ms;
    logic [nat_pkg::HOLD_W-1:0] hold;
    int                         gap_pct;
  } plan_step_t;

  typedef struct packed {
    logic [2:0]                        ev;
    logic [nat_pkg::ADDR_W-1:0]        node;
    logic [nat_pkg::ENTRY_COUNT_W-1:0] count;
    logic                              fin;
  } table_event_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        mode = nat_pkg::MODE_HELLO;
  logic [nat_pkg::ADDR_W-1:0]        sender_address = '0;
  logic [nat_pkg::TIME_W-1:0]        now_ms = '0;
  logic                              hold_we = 1'b0;
  logic [nat_pkg::HOLD_W-1:0]        hold_time_ms = '0;
  logic                              result_strobe;
  logic [2:0]                        event_res;
  logic [nat_pkg::ADDR_W-1:0]        node_address;
  logic [nat_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic                              last;

  // Mirror of the table as the block should hold it.
  logic [nat_pkg::ADDR_W-1:0]  addr_mirror [DEPTH];
  logic [nat_pkg::TIME_W-1:0]  due_mirror [DEPTH];
  int                          listed_mirror;
  logic [nat_pkg::HOLD_W-1:0]  hold_mirror;

  plan_step_t                 beat_plan[$];
  table_event_t               expected_events[$];
  logic [nat_pkg::TIME_W-1:0] clock_ms;

  int beats_offered;
  int beats_in;
  int settle_cnt;
  int events_checked;
  int full_seen;
  int disappear_seen;
  int errors;

  neighbor_aging_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .sender_address (sender_address),
    .now_ms         (now_ms),
    .hold_we        (hold_we),
    .hold_time_ms   (hold_time_ms),
    .result_strobe  (result_strobe),
    .event_res      (event_res),
    .node_address   (node_address),
    .entry_count    (entry_count),
    .last           (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void queue_event(logic [2:0] ev, logic [nat_pkg::ADDR_W-1:0] node,
                                      logic fin);
    table_event_t e;
    e.ev    = ev;
    e.node  = node;
    e.count = nat_pkg::ENTRY_COUNT_W'(listed_mirror);
    e.fin   = fin;
    expected_events.push_back(e);
  endfunction

  task automatic predict_table_events(input logic [1:0] op,
                                      input logic [nat_pkg::ADDR_W-1:0] who,
                                      input logic [nat_pkg::TIME_W-1:0] at_ms);
    logic [nat_pkg::TIME_W-1:0] due;
    int                         total;
    int                         kept;
    int                         hit;
    due = at_ms + nat_pkg::TIME_W'(hold_mirror);
    case (op)
      nat_pkg::MODE_HELLO: begin
        hit = -1;
        for (int i = 0; i < listed_mirror; i++) begin
          if (hit < 0 && addr_mirror[i] == who) hit = i;
        end
        if (hit >= 0) begin
          due_mirror[hit] = due;
          queue_event(nat_pkg::EV_REFRESH, who, 1'b1);
        end else if (listed_mirror >= DEPTH) begin
          queue_event(nat_pkg::EV_FULL, who, 1'b1);
        end else begin
          addr_mirror[listed_mirror] = who;
          due_mirror[listed_mirror]  = due;
          listed_mirror++;
          queue_event(nat_pkg::EV_APPEAR, who, 1'b1);
        end
      end
      nat_pkg::MODE_SWEEP: begin
        // Expired entries drop out; survivors close up in their old order.
        total = listed_mirror;
        kept  = 0;
        for (int i = 0; i < total; i++) begin
          if (due_mirror[i] < at_ms) begin
            listed_mirror--;
            queue_event(nat_pkg::EV_DISAPPEAR, addr_mirror[i], 1'b0);
          end else begin
            addr_mirror[kept] = addr_mirror[i];
            due_mirror[kept]  = due_mirror[i];
            kept++;
          end
        end
        queue_event(nat_pkg::EV_SWEEP_DONE, '0, 1'b1);
      end
      nat_pkg::MODE_CLEAR: begin
        listed_mirror = 0;
        queue_event(nat_pkg::EV_CLEARED, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_step(input step_kind_t kind, input logic [1:0] op,
                          input logic [nat_pkg::ADDR_W-1:0] who,
                          input logic [nat_pkg::TIME_W-1:0] at_ms,
                          input logic [nat_pkg::HOLD_W-1:0] hold, input int gap_pct);
    plan_step_t s;
    s.kind    = kind;
    s.op      = op;
    s.who     = who;
    s.at_ms   = at_ms;
    s.hold    = hold;
    s.gap_pct = gap_pct;
    beat_plan.push_back(s);
  endtask

  // Mostly hellos from a small address pool with time moving forward, so that
  // entries refresh, expire and fill the table; a few stray beats mixed in.
  task automatic add_session(input int n, input int gap_pct,
                             input logic [nat_pkg::HOLD_W-1:0] hold);
    logic [nat_pkg::ADDR_W-1:0] pool [20];
    int                         roll;
    for (int k = 0; k < 20; k++) pool[k] = nat_pkg::ADDR_W'($urandom);
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      clock_ms += nat_pkg::TIME_W'($urandom_range(0, hold / 3 + 3));
      if (roll < 72)
        add_step(STEP_BEAT, nat_pkg::MODE_HELLO, pool[$urandom_range(19)], clock_ms, '0,
                 gap_pct);
      else if (roll < 90)
        add_step(STEP_BEAT, nat_pkg::MODE_SWEEP, nat_pkg::ADDR_W'($urandom), clock_ms, '0,
                 gap_pct);
      else if (roll < 93)
        add_step(STEP_BEAT, nat_pkg::MODE_CLEAR, nat_pkg::ADDR_W'($urandom), clock_ms, '0,
                 gap_pct);
      else if (roll < 96)
        add_step(STEP_BEAT, nat_pkg::MODE_NONE, nat_pkg::ADDR_W'($urandom),
                 nat_pkg::TIME_W'($urandom), '0, gap_pct);
      else
        add_step(STEP_BEAT, 2'($urandom_range(2)), nat_pkg::ADDR_W'($urandom),
                 nat_pkg::TIME_W'($urandom), '0, gap_pct);
    end
  endtask

  // Driver: offers one beat at a time, holding it until the block takes it.
  always @(negedge clk) begin : drive_proc
    logic       go;
    logic       we;
    plan_step_t step;
    if (rst) begin
      start   <= 1'b0;
      hold_we <= 1'b0;
    end else begin
      go = start && (beats_in != beats_offered);
      we = 1'b0;
      if (expected_events.size() == 0 && !busy && !start && !result_strobe)
        settle_cnt++;
      else
        settle_cnt = 0;
      if (!go && beat_plan.size() != 0) begin
        step = beat_plan[0];
        case (step.kind)
          STEP_BEAT: if ($urandom_range(99) >= step.gap_pct) begin
            mode           <= step.op;
            sender_address <= step.who;
            now_ms         <= step.at_ms;
            go = 1'b1;
            beats_offered++;
            void'(beat_plan.pop_front());
          end
          STEP_HOLD_WRITE: if (settle_cnt >= SETTLE) begin
            we = 1'b1;
            hold_time_ms <= step.hold;
            settle_cnt = 0;
            void'(beat_plan.pop_front());
          end
          default: if (settle_cnt >= SETTLE) begin
            void'(beat_plan.pop_front());
          end
        endcase
      end
      start   <= go;
      hold_we <= we;
    end
  end

  // Monitor: checks result beats, then records newly accepted beats.
  always @(posedge clk) begin : watch_proc
    table_event_t want;
    if (rst) begin
      hold_mirror   = nat_pkg::HOLD_RESET;
      listed_mirror = 0;
    end else begin
      if (result_strobe) begin
        if (event_res == nat_pkg::EV_FULL) full_seen++;
        if (event_res == nat_pkg::EV_DISAPPEAR) disappear_seen++;
        if (expected_events.size() == 0) begin
          $error("result with none pending: event_res %0d node_address %0d", event_res,
                 node_address);
          errors++;
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            errors++;
          end
          if (node_address !== want.node) begin
            $error("node_address: expected %0d, got %0d", want.node, node_address);
            errors++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            errors++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, last);
            errors++;
          end
        end
      end
      if (hold_we) hold_mirror = hold_time_ms;
      if (start && !busy) begin
        predict_table_events(mode, sender_address, now_ms);
        beats_in++;
      end
    end
  end

  initial begin
    // Directed part: empty table, wrap of the deadline, refresh, fill to full.
    add_step(STEP_BEAT, nat_pkg::MODE_SWEEP, 8'h00, 32'h0000_0000, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_CLEAR, 8'hFF, 32'hFFFF_FFFF, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_NONE, 8'hAA, 32'hFFFF_FFFF, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_HELLO, 8'h00, 32'h0000_0000, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_HELLO, 8'hFF, 32'hFFFF_FFFF, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_HELLO, 8'h00, 32'h0000_000A, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_SWEEP, 8'h55, 32'd5000, '0, 0);
    for (int k = 1; k < DEPTH; k++)
      add_step(STEP_BEAT, nat_pkg::MODE_HELLO, nat_pkg::ADDR_W'(k * 17),
               nat_pkg::TIME_W'(100 + k), '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_HELLO, 8'h80, 32'd200, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_HELLO, 8'h00, 32'd201, '0, 0);
    add_step(STEP_BEAT, nat_pkg::MODE_SWEEP, 8'h00, 32'hFFFF_FFFF, '0, 0);

    clock_ms = nat_pkg::TIME_W'($urandom);
    add_session(60, 0, nat_pkg::HOLD_RESET);
    add_step(STEP_HOLD_WRITE, nat_pkg::MODE_NONE, '0, '0, 16'd0, 0);
    add_session(45, 85, 16'd0);
    add_step(STEP_HOLD_WRITE, nat_pkg::MODE_NONE, '0, '0, 16'hFFFF, 0);
    clock_ms = 32'hFFFE_8000;
    add_session(30, 16, 16'hFFFF);
    add_step(STEP_DRAIN, nat_pkg::MODE_NONE, '0, '0, '0, 0);
    add_session(30, 16, 16'hFFFF);
    add_step(STEP_HOLD_WRITE, nat_pkg::MODE_NONE, '0, '0, 16'd1, 0);
    add_session(50, 0, 16'd1);
    add_step(STEP_HOLD_WRITE, nat_pkg::MODE_NONE, '0, '0,
             nat_pkg::HOLD_W'($urandom_range(2, 2000)), 0);
    clock_ms = nat_pkg::TIME_W'($urandom);
    for (int k = 0; k < 6; k++) add_session(8, (k % 3 == 0) ? 0 : (k % 3 == 1) ? 85 : 16, 2000);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beat_plan.size() != 0 || start || expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      errors++;
    end
    $display("Ran %0d beats through hello, sweep, clear and unused modes at five hold values;",
             beats_in);
    $display("checked %0d result beats, %0d table full, %0d disappear.", events_checked,
             full_seen, disappear_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out waiting for the block.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### neighbor_aging_table.f
+incdir+design
design/nat_pkg.sv
design/nat_ctrl.sv
design/nat_dp.sv
design/neighbor_aging_table.sv
dv/tb_top.sv
